@@ rtl/bcps_pkg.sv @@
// shared types, constants and helpers for the binary corner point search core
package bcps_pkg;

	// field and counter widths
	localparam int MAX_DIM = 4096;
	localparam int COORD_W = 12;
	localparam int DIM_W = 13;
	localparam int DIST_W = 26;
	localparam int GRAY_W = 8;
	localparam int MODE_W = 2;

	// row queue size
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	// configuration register reset values
	localparam logic [GRAY_W-1:0] THRESHOLD_RESET = 8'd150;
	localparam logic [DIM_W-1:0] DIM_RESET = 13'd64;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;
	localparam logic [1:0] REG_WIDTH = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	// corner selection
	typedef enum logic [MODE_W-1:0] {
		CORNER_TOP_LEFT = 2'd0,
		CORNER_TOP_RIGHT = 2'd1,
		CORNER_BOTTOM_RIGHT = 2'd2,
		CORNER_BOTTOM_LEFT = 2'd3
	} corner_mode_t;

	// live configuration, sizes already clamped to 1..MAX_DIM
	typedef struct packed {
		logic [GRAY_W-1:0] threshold;
		corner_mode_t mode;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	// one finished row handed from the front to the back
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic cand;
		logic last;
	} row_rec_t;

	// a size of zero acts as one, above the maximum acts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic is_right(input corner_mode_t m);
		return (m == CORNER_TOP_RIGHT) || (m == CORNER_BOTTOM_RIGHT);
	endfunction

	function automatic logic is_bottom(input corner_mode_t m);
		return (m == CORNER_BOTTOM_RIGHT) || (m == CORNER_BOTTOM_LEFT);
	endfunction

endpackage

@@ rtl/binary_corner_point_search_core.sv @@
// top level of the binary corner point search core: register file and wiring
//
//  channel   direction  request contents
//  s_axis    in         one gray pixel of the tile, raster order
//  m_axis    out        one corner result per tile
//  apb       in/out     threshold, corner mode, tile width, tile height
//
// One pixel is taken every cycle. A row end with a candidate, or one closing the
// tile, passes into a four-row queue, and the back end clears one row a cycle
// through a distance pipeline of offset and square stages. A stalled result
// holds the back end; the front stalls only on a row end with the queue full.
// Reset needs no clearing pass: the block takes pixels straight out of reset.
module binary_corner_point_search_core (
	input  logic clk,
	input  logic arst_n,
	// pixel input
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] gray_level
	// result output
	output logic m_tvalid,
	input  logic m_tready,
	output logic [55:0] m_tdata,  // [0] corner_found, [12:1] corner_x,
	                              // [24:13] corner_y, [50:25] corner_distance
	// configuration
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bcps_pkg::*;

	logic [GRAY_W-1:0] threshold_q;
	corner_mode_t mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	cfg_t cfg;
	logic wr_en;
	logic [1:0] reg_idx;

	logic push;
	row_rec_t push_rec;
	logic queue_full;
	logic pop;
	row_rec_t pop_rec;
	logic queue_empty;

	logic corner_found;
	logic [COORD_W-1:0] corner_x;
	logic [COORD_W-1:0] corner_y;
	logic [DIST_W-1:0] corner_distance;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			mode_q <= CORNER_TOP_LEFT;
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[GRAY_W-1:0];
				REG_MODE: mode_q <= corner_mode_t'(pwdata[MODE_W-1:0]);
				REG_WIDTH: width_q <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = {{(32-GRAY_W){1'b0}}, threshold_q};
			REG_MODE: prdata = {{(32-MODE_W){1'b0}}, mode_q};
			REG_WIDTH: prdata = {{(32-DIM_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_q};
			default: prdata = '0;
		endcase
	end

	// working configuration with clamped sizes
	assign cfg = '{threshold: threshold_q, mode: mode_q,
		width: clamp_dim(width_q), height: clamp_dim(height_q)};

	bcps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.gray_level(s_tdata),
		.queue_full(queue_full),
		.push(push),
		.push_rec(push_rec)
	);

	bcps_row_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_rec(push_rec),
		.full(queue_full),
		.pop(pop),
		.pop_rec(pop_rec),
		.empty(queue_empty)
	);

	bcps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.queue_empty(queue_empty),
		.pop_rec(pop_rec),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.corner_found(corner_found),
		.corner_x(corner_x),
		.corner_y(corner_y),
		.corner_distance(corner_distance)
	);

	// result packing, padded to whole bytes
	assign m_tdata = {5'd0, corner_distance, corner_y, corner_x, corner_found};

endmodule

@@ rtl/bcps_front.sv @@
// front end: pixel counting, dark test and per-row candidate selection
module bcps_front (
	input  logic clk,
	input  logic arst_n,
	input  bcps_pkg::cfg_t cfg,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [bcps_pkg::GRAY_W-1:0] gray_level,
	input  logic queue_full,
	output logic push,
	output bcps_pkg::row_rec_t push_rec
);
	import bcps_pkg::*;

	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] cand_col_q;
	logic cand_valid_q;

	logic dark;
	logic take_pix;
	logic row_end;
	logic tile_end;
	logic accept;
	logic [COORD_W-1:0] cand_col_n;
	logic cand_valid_n;

	// pixel classification and candidate choice
	always_comb begin
		dark = gray_level <= cfg.threshold;
		take_pix = dark && (is_right(cfg.mode) || !cand_valid_q);
		cand_col_n = take_pix ? column_q : cand_col_q;
		cand_valid_n = cand_valid_q || dark;
		row_end = ({1'b0, column_q} + DIM_W'(1)) >= cfg.width;
		tile_end = ({1'b0, row_q} + DIM_W'(1)) >= cfg.height;
	end

	// stall only a row-ending pixel when the queue is full
	assign s_tready = !queue_full || !row_end;
	assign accept = s_tvalid && s_tready;

	// rows without a candidate are dropped unless they close the tile
	assign push = accept && row_end && (cand_valid_n || tile_end);
	assign push_rec = '{col: cand_col_n, row: row_q, cand: cand_valid_n, last: tile_end};

	// position counters and row candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
			cand_col_q <= '0;
			cand_valid_q <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				column_q <= '0;
				cand_col_q <= '0;
				cand_valid_q <= 1'b0;
				row_q <= tile_end ? '0 : row_q + COORD_W'(1);
			end else begin
				column_q <= column_q + COORD_W'(1);
				cand_col_q <= cand_col_n;
				cand_valid_q <= cand_valid_n;
			end
		end
	end

endmodule

@@ rtl/bcps_row_queue.sv @@
// small queue of finished rows between the front and the back
module bcps_row_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  bcps_pkg::row_rec_t push_rec,
	output logic full,
	input  logic pop,
	output bcps_pkg::row_rec_t pop_rec,
	output logic empty
);
	import bcps_pkg::*;

	row_rec_t mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_rec = mem[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

@@ rtl/bcps_back.sv @@
// back end: row distance pipeline, best-row tracking and result register
module bcps_back (
	input  logic clk,
	input  logic arst_n,
	input  bcps_pkg::cfg_t cfg,
	input  logic queue_empty,
	input  bcps_pkg::row_rec_t pop_rec,
	output logic pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic corner_found,
	output logic [bcps_pkg::COORD_W-1:0] corner_x,
	output logic [bcps_pkg::COORD_W-1:0] corner_y,
	output logic [bcps_pkg::DIST_W-1:0] corner_distance
);
	import bcps_pkg::*;

	// stage 1: offsets to the corner point
	logic valid_s1;
	row_rec_t rec_s1;
	logic [DIM_W-1:0] dx_s1;
	logic [DIM_W-1:0] dy_s1;
	// stage 2: squared offsets
	logic valid_s2;
	row_rec_t rec_s2;
	logic [DIST_W-1:0] sqx_s2;
	logic [DIST_W-1:0] sqy_s2;
	// tile best
	logic [DIST_W-1:0] best_dist_q;
	logic [COORD_W-1:0] best_x_q;
	logic [COORD_W-1:0] best_y_q;
	logic any_found_q;
	// result register
	logic out_valid_q;
	logic found_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [DIST_W-1:0] dist_q;

	logic adv;
	logic emit;
	logic [DIST_W-1:0] row_dist;
	logic take;
	logic [DIST_W-1:0] nb_dist;
	logic [COORD_W-1:0] nb_x;
	logic [COORD_W-1:0] nb_y;
	logic nb_found;
	logic [DIM_W-1:0] dx_n;
	logic [DIM_W-1:0] dy_n;

	// hold the whole pipeline while a tile result cannot be placed
	assign adv = !(valid_s2 && rec_s2.last && out_valid_q && !m_tready);
	assign pop = adv && !queue_empty;
	assign emit = valid_s2 && rec_s2.last && adv;

	// offsets, corner point picked by the mode
	always_comb begin
		dx_n = is_right(cfg.mode) ? cfg.width - {1'b0, pop_rec.col} : {1'b0, pop_rec.col};
		dy_n = is_bottom(cfg.mode) ? cfg.height - {1'b0, pop_rec.row} : {1'b0, pop_rec.row};
	end

	// distance compare and best update, ties kept by the older row in bottom right
	always_comb begin
		row_dist = sqx_s2 + sqy_s2;
		if (!rec_s2.cand) begin
			take = 1'b0;
		end else if (!any_found_q) begin
			take = 1'b1;
		end else if (cfg.mode == CORNER_BOTTOM_RIGHT) begin
			take = row_dist < best_dist_q;
		end else begin
			take = row_dist <= best_dist_q;
		end
		nb_dist = take ? row_dist : best_dist_q;
		nb_x = take ? rec_s2.col : best_x_q;
		nb_y = take ? rec_s2.row : best_y_q;
		nb_found = any_found_q || take;
	end

	// pipeline valids, best state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			best_dist_q <= '1;
			best_x_q <= '0;
			best_y_q <= '0;
			any_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= pop;
				valid_s2 <= valid_s1;
			end
			if (emit) begin
				best_dist_q <= '1;
				best_x_q <= '0;
				best_y_q <= '0;
				any_found_q <= 1'b0;
			end else if (valid_s2 && adv) begin
				best_dist_q <= nb_dist;
				best_x_q <= nb_x;
				best_y_q <= nb_y;
				any_found_q <= nb_found;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pipeline payload and result fields
	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1 <= pop_rec;
			dx_s1 <= dx_n;
			dy_s1 <= dy_n;
			rec_s2 <= rec_s1;
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
		end
		if (emit) begin
			found_q <= nb_found;
			x_q <= nb_found ? nb_x : '0;
			y_q <= nb_found ? nb_y : '0;
			dist_q <= nb_found ? nb_dist : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign corner_found = found_q;
	assign corner_x = x_q;
	assign corner_y = y_q;
	assign corner_distance = dist_q;

endmodule

@@ sim/binary_corner_point_search_core_tb.sv @@
// self-checking testbench for the binary corner point search core
module binary_corner_point_search_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcps_pkg::*;

	localparam int ITEMS_PER_PHASE = 480;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_EDGE = 200;

	// one corner result as carried on the output stream
	typedef struct packed {
		logic found;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIST_W-1:0] sq_dist;
	} corner_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [7:0] pending_pixels[$];
	corner_result_t expected_corners[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// predictor copy of the registers
	logic [GRAY_W-1:0] thr_reg = THRESHOLD_RESET;
	corner_mode_t mode_reg = CORNER_TOP_LEFT;
	logic [DIM_W-1:0] width_reg = DIM_RESET;
	logic [DIM_W-1:0] height_reg = DIM_RESET;

	// predictor copy of the tile scan state
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned cand_col = 0;
	bit cand_valid = 1'b0;
	longint unsigned best_d = 64'h3FFFFFF;
	int unsigned best_col = 0;
	int unsigned best_row = 0;
	bit seen_dark = 1'b0;

	binary_corner_point_search_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// tile sizes of zero act as one, oversize acts as the maximum
	function automatic int unsigned effective_size(input logic [DIM_W-1:0] v);
		int unsigned r;
		r = v;
		if (r == 0) begin
			r = 1;
		end else if (r > MAX_DIM) begin
			r = MAX_DIM;
		end
		return r;
	endfunction

	// advance the scan by one pixel, queue the corner at tile end
	task automatic predict_pixel(input logic [GRAY_W-1:0] gray);
		int unsigned w, h, cx, cy, dx, dy;
		longint unsigned d;
		bit right_side, bottom_side, take;
		corner_result_t r;
		w = effective_size(width_reg);
		h = effective_size(height_reg);
		right_side = (mode_reg == CORNER_TOP_RIGHT) || (mode_reg == CORNER_BOTTOM_RIGHT);
		bottom_side = (mode_reg == CORNER_BOTTOM_RIGHT) || (mode_reg == CORNER_BOTTOM_LEFT);
		// left corners keep the first dark pixel, right corners the last
		if (gray <= thr_reg && (right_side || !cand_valid)) begin
			cand_col = col_pos;
			cand_valid = 1'b1;
		end
		if (col_pos + 1 < w) begin
			col_pos++;
		end else begin
			// row end: weigh the row candidate against the best so far
			if (cand_valid) begin
				cx = right_side ? w : 0;
				cy = bottom_side ? h : 0;
				dx = (cand_col >= cx) ? cand_col - cx : cx - cand_col;
				dy = (row_pos >= cy) ? row_pos - cy : cy - row_pos;
				d = longint'(dx) * dx + longint'(dy) * dy;
				if (!seen_dark) begin
					take = 1'b1;
				end else if (mode_reg == CORNER_BOTTOM_RIGHT) begin
					take = d < best_d;
				end else begin
					take = d <= best_d;
				end
				if (take) begin
					best_d = d;
					best_col = cand_col;
					best_row = row_pos;
					seen_dark = 1'b1;
				end
			end
			col_pos = 0;
			cand_col = 0;
			cand_valid = 1'b0;
			if (row_pos + 1 < h) begin
				row_pos++;
			end else begin
				// tile end: one result, then a fresh tile
				r.found = seen_dark;
				r.x = seen_dark ? COORD_W'(best_col) : '0;
				r.y = seen_dark ? COORD_W'(best_row) : '0;
				r.sq_dist = seen_dark ? DIST_W'(best_d) : '0;
				expected_corners = {expected_corners, r};
				row_pos = 0;
				best_d = 64'h3FFFFFF;
				best_col = 0;
				best_row = 0;
				seen_dark = 1'b0;
			end
		end
	endtask

	// track register writes and accepted pixel requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_THRESHOLD: thr_reg = pwdata[GRAY_W-1:0];
					REG_MODE: mode_reg = corner_mode_t'(pwdata[MODE_W-1:0]);
					REG_WIDTH: width_reg = pwdata[DIM_W-1:0];
					REG_HEIGHT: height_reg = pwdata[DIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_pixel(s_tdata);
			end
		end
	end

	// compare each accepted result with the oldest expected corner
	always @(posedge clk) begin : check_results
		corner_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.x = m_tdata[12:1];
			got.y = m_tdata[24:13];
			got.sq_dist = m_tdata[50:25];
			if (expected_corners.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending: found %0d x %0d y %0d dist %0d",
					got.found, got.x, got.y, got.sq_dist));
			end else begin
				want = expected_corners.pop_front();
				if (got.found !== want.found)
					flag_mismatch($sformatf("corner_found %0d, want %0d", got.found, want.found));
				if (got.x !== want.x)
					flag_mismatch($sformatf("corner_x %0d, want %0d", got.x, want.x));
				if (got.y !== want.y)
					flag_mismatch($sformatf("corner_y %0d, want %0d", got.y, want.y));
				if (got.sq_dist !== want.sq_dist)
					flag_mismatch($sformatf("corner_distance %0d, want %0d",
						got.sq_dist, want.sq_dist));
			end
		end
	end

	// pixel driver and result back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_pixels.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic apb_access(input logic write, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers(input logic [7:0] thr, input corner_mode_t mode,
			input logic [12:0] w, input logic [12:0] h);
		logic [31:0] rd;
		apb_access(1'b0, REG_THRESHOLD, '0, rd);
		if (rd !== 32'(thr)) flag_mismatch($sformatf("threshold reads %0d, want %0d", rd, thr));
		apb_access(1'b0, REG_MODE, '0, rd);
		if (rd !== 32'(mode)) flag_mismatch($sformatf("corner mode reads %0d, want %0d", rd, mode));
		apb_access(1'b0, REG_WIDTH, '0, rd);
		if (rd !== 32'(w)) flag_mismatch($sformatf("tile width reads %0d, want %0d", rd, w));
		apb_access(1'b0, REG_HEIGHT, '0, rd);
		if (rd !== 32'(h)) flag_mismatch($sformatf("tile height reads %0d, want %0d", rd, h));
	endtask

	// wait until every pixel is taken and every corner is back
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_pixels.size() != 0 || s_tvalid || expected_corners.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] thr, input corner_mode_t mode,
			input logic [12:0] w, input logic [12:0] h);
		logic [31:0] rd;
		wait_idle();
		apb_access(1'b1, REG_THRESHOLD, 32'(thr), rd);
		apb_access(1'b1, REG_MODE, 32'(mode), rd);
		apb_access(1'b1, REG_WIDTH, 32'(w), rd);
		apb_access(1'b1, REG_HEIGHT, 32'(h), rd);
		check_registers(thr, mode, w, h);
	endtask

	// first listed pixel goes out first
	task automatic push_packed(input logic [71:0] pix, input int count);
		for (int i = count - 1; i >= 0; i--) begin
			pending_pixels = {pending_pixels, pix[8*i +: 8]};
		end
	endtask

	function automatic logic [7:0] pick_gray(input logic [7:0] thr, input int unsigned dark_pct);
		logic [7:0] g;
		if ($urandom_range(0, 99) < dark_pct) begin
			g = 8'($urandom_range(0, thr));
		end else if (thr == 8'hFF) begin
			g = 8'($urandom_range(0, 255));
		end else begin
			g = 8'($urandom_range(thr + 1, 255));
		end
		return g;
	endfunction

	// mostly small tiles, now and then a zero or a wider one
	function automatic logic [12:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) return 13'd0;
		if (r == 1) return 13'($urandom_range(9, 24));
		return 13'($urandom_range(1, 8));
	endfunction

	task automatic queue_pixels(input logic [7:0] thr, input int unsigned count,
			input int unsigned dark_pct);
		for (int unsigned i = 0; i < count; i++) begin
			pending_pixels = {pending_pixels, pick_gray(thr, dark_pct)};
		end
	endtask

	// reset, directed tiles, random tiles under three idling patterns, then long thin tiles
	initial begin : stimulus
		logic [7:0] thr;
		corner_mode_t mode;
		logic [12:0] w, h;
		int unsigned tiles, dark_pct, sent, pick, tile_pixels;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		check_registers(THRESHOLD_RESET, CORNER_TOP_LEFT, DIM_RESET, DIM_RESET);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				// single pixel tiles: dark, light, at the threshold, just above it
				set_config(8'd150, CORNER_TOP_LEFT, 13'd1, 13'd1);
				push_packed({8'd0, 8'd255, 8'd150, 8'd151}, 4);
				// zero sizes act as one, threshold of zero
				set_config(8'd0, CORNER_TOP_RIGHT, 13'd0, 13'd0);
				push_packed({8'd0, 8'd1}, 2);
				// everything dark at the top threshold
				set_config(8'd255, CORNER_BOTTOM_LEFT, 13'd2, 13'd2);
				push_packed({4{8'd255}}, 4);
				// equal distances: lower row wins
				set_config(8'd100, CORNER_TOP_LEFT, 13'd3, 13'd3);
				push_packed({8'd200, 8'd50, 8'd200, 8'd50, 8'd200, 8'd200,
					8'd200, 8'd200, 8'd200}, 9);
				// equal distances at bottom right: upper row wins
				set_config(8'd100, CORNER_BOTTOM_RIGHT, 13'd3, 13'd3);
				push_packed({8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd50,
					8'd200, 8'd50, 8'd200}, 9);
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 7);
				thr = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
				mode = corner_mode_t'($urandom_range(0, 3));
				w = pick_size();
				h = pick_size();
				tile_pixels = effective_size(w) * effective_size(h);
				tiles = (tile_pixels > 64) ? 1 : $urandom_range(1, 4);
				case ($urandom_range(0, 4))
					0: dark_pct = 0;
					1: dark_pct = 5;
					2: dark_pct = 30;
					3: dark_pct = 70;
					default: dark_pct = 100;
				endcase
				set_config(thr, mode, w, h);
				queue_pixels(thr, tiles * tile_pixels, dark_pct);
				sent += tiles * tile_pixels;
			end
			if (phase == 2) begin
				// long thin tiles: one wide row, one tall column
				thr = 8'($urandom_range(0, 255));
				set_config(thr, corner_mode_t'($urandom_range(0, 3)), 13'(LONG_EDGE), 13'd1);
				queue_pixels(thr, LONG_EDGE, 3);
				thr = 8'($urandom_range(0, 255));
				set_config(thr, corner_mode_t'($urandom_range(0, 3)), 13'd0, 13'(LONG_EDGE));
				queue_pixels(thr, LONG_EDGE, 3);
			end
		end
		wait_idle();
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ binary_corner_point_search_core.f @@
rtl/bcps_pkg.sv
rtl/bcps_front.sv
rtl/bcps_row_queue.sv
rtl/bcps_back.sv
rtl/binary_corner_point_search_core.sv
sim/binary_corner_point_search_core_tb.sv
